// ----- rtl/kdb_pkg.sv -----
// ----------------------------------------------------------------------------
// kdb_pkg
// Shared types, constants and helpers for the key debounce and event FIFO block.
// ----------------------------------------------------------------------------
package kdb_pkg;

    // Key and code geometry.
    localparam int NUM_KEYS = 3;
    localparam int KEY_W    = 2;
    localparam int CNT_W    = 4;
    localparam int TICK_W   = 16;
    localparam int CODE_W   = 4;
    localparam int CFG_IDX_W = 3;

    // Debounce filter length in scan ticks.
    localparam int FILTER_TICKS = 5;
    localparam logic [CNT_W-1:0] FILTER_CNT = CNT_W'(FILTER_TICKS);
    localparam logic [CNT_W-1:0] HOLD_CNT   = CNT_W'(2 * FILTER_TICKS);
    localparam logic [CNT_W-1:0] START_CNT  = CNT_W'(FILTER_TICKS / 2);

    // Highest key index.
    localparam logic [KEY_W-1:0] KEY_LAST = KEY_W'(NUM_KEYS - 1);

    // Event kinds; the pushed code is three times the key index plus the kind.
    localparam logic [1:0] EV_PRESS   = 2'd1;
    localparam logic [1:0] EV_RELEASE = 2'd2;
    localparam logic [1:0] EV_LONG    = 2'd3;

    // Item kinds on the input channel.
    localparam logic FUNC_TICK = 1'b0;
    localparam logic FUNC_READ = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_KEY0   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_KEY1   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_KEY2   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_KEY0 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_KEY1 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_KEY2 = 3'd5;

    // Register values after reset.
    localparam logic [TICK_W-1:0] LONG_RESET   [NUM_KEYS] = '{16'd0, 16'd100, 16'd0};
    localparam logic [TICK_W-1:0] REPEAT_RESET [NUM_KEYS] = '{16'd500, 16'd0, 16'd0};

    // Per-key debounce state held in the key memory.
    typedef struct packed {
        logic [CNT_W-1:0]  cnt;
        logic              pressed;
        logic [TICK_W-1:0] long_cnt;
        logic [TICK_W-1:0] rep_cnt;
    } t_key_state;

    localparam t_key_state KEY_STATE_RESET = '{
        cnt: START_CNT, pressed: 1'b0, long_cnt: '0, rep_cnt: '0};

    // Up to two codes produced by one key in one scan tick, in push order.
    typedef struct packed {
        logic              a_vld;
        logic [CODE_W-1:0] code_a;
        logic              b_vld;
        logic [CODE_W-1:0] code_b;
    } t_key_ev;

    // Request from the sequencer to the code FIFO.
    typedef struct packed {
        logic              push;
        logic [CODE_W-1:0] code;
        logic              pop;
    } t_fifo_req;

    // Event code for a key and an event kind.
    function automatic logic [CODE_W-1:0] ev_code(input logic [KEY_W-1:0] key,
                                                   input logic [1:0] kind);
        ev_code = CODE_W'({key, 1'b0}) + {2'b00, key} + {2'b00, kind};
    endfunction

endpackage

// ----- rtl/kdb_key_step.sv -----
// ----------------------------------------------------------------------------
// kdb_key_step
// Next-state logic of one key's debounce, long-press and repeat machine.
// ----------------------------------------------------------------------------
module kdb_key_step (
    input  kdb_pkg::t_key_state          i_state,
    input  logic                         i_down,
    input  logic [kdb_pkg::KEY_W-1:0]    i_key,
    input  logic [kdb_pkg::TICK_W-1:0]   i_long_ticks,
    input  logic [kdb_pkg::TICK_W-1:0]   i_rep_ticks,
    output kdb_pkg::t_key_state          o_state,
    output kdb_pkg::t_key_ev             o_ev
);
    import kdb_pkg::*;

    logic              press_push;
    logic              other_push;
    logic [CODE_W-1:0] other_code;
    logic [TICK_W-1:0] long_inc;
    logic [TICK_W-1:0] rep_inc;

    assign long_inc = i_state.long_cnt + TICK_W'(1);
    assign rep_inc  = i_state.rep_cnt + TICK_W'(1);

    // Debounce counter, press and release detection, long and repeat counts.
    always_comb begin
        o_state    = i_state;
        press_push = 1'b0;
        other_push = 1'b0;
        other_code = ev_code(i_key, EV_PRESS);
        if (i_down) begin
            if (i_state.cnt < FILTER_CNT) begin
                o_state.cnt = FILTER_CNT;
            end else if (i_state.cnt < HOLD_CNT) begin
                o_state.cnt = i_state.cnt + CNT_W'(1);
            end else begin
                if (!i_state.pressed) begin
                    o_state.pressed = 1'b1;
                    press_push      = 1'b1;
                end
                if (i_long_ticks != '0) begin
                    if (i_state.long_cnt < i_long_ticks) begin
                        o_state.long_cnt = long_inc;
                        if (long_inc == i_long_ticks) begin
                            other_push = 1'b1;
                            other_code = ev_code(i_key, EV_LONG);
                        end
                    end
                end else if (i_rep_ticks != '0) begin
                    o_state.rep_cnt = rep_inc;
                    if (rep_inc >= i_rep_ticks) begin
                        o_state.rep_cnt = '0;
                        other_push      = 1'b1;
                    end
                end
            end
        end else begin
            if (i_state.cnt >= FILTER_CNT) begin
                o_state.cnt = FILTER_CNT;
            end else if (i_state.cnt != '0) begin
                o_state.cnt = i_state.cnt - CNT_W'(1);
            end else if (i_state.pressed) begin
                o_state.pressed = 1'b0;
                other_push      = 1'b1;
                other_code      = ev_code(i_key, EV_RELEASE);
            end
            o_state.long_cnt = '0;
        end
    end

    // Order the codes: the press always goes first.
    always_comb begin
        o_ev = '0;
        if (press_push) begin
            o_ev.a_vld  = 1'b1;
            o_ev.code_a = ev_code(i_key, EV_PRESS);
            o_ev.b_vld  = other_push;
            o_ev.code_b = other_code;
        end else begin
            o_ev.a_vld  = other_push;
            o_ev.code_a = other_code;
        end
    end

endmodule

// ----- rtl/kdb_code_fifo.sv -----
// ----------------------------------------------------------------------------
// kdb_code_fifo
// Circular event code store with registered read; pushes always win.
// ----------------------------------------------------------------------------
module kdb_code_fifo #(
    parameter int DEPTH = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  kdb_pkg::t_fifo_req          i_req,
    output logic                        o_empty,
    output logic [kdb_pkg::CODE_W-1:0]  o_rd_code
);
    import kdb_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    logic [CODE_W-1:0] r_mem [DEPTH];
    logic [CODE_W-1:0] r_rd_code;
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [PTR_W-1:0]  n_wr_ptr;
    logic [PTR_W-1:0]  n_rd_ptr;

    // Pointer advance with wrap at the store depth.
    always_comb begin
        n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PTR_W'(1);
        n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PTR_W'(1);
    end

    // Pointers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
        end else begin
            if (i_req.push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (i_req.pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
        end
    end

    // Code store: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_req.push) begin
            r_mem[r_wr_ptr] <= i_req.code;
        end
        if (i_req.pop) begin
            r_rd_code <= r_mem[r_rd_ptr];
        end
    end

    assign o_empty   = (r_rd_ptr == r_wr_ptr);
    assign o_rd_code = r_rd_code;

    // Both pointers stay inside the store.
    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wr_ptr <= PTR_LAST) && (r_rd_ptr <= PTR_LAST))
        else $error("FIFO pointer beyond store depth");

    // Only real event codes are ever pushed.
    a_push_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.push |-> (i_req.code != '0))
        else $error("empty code pushed into FIFO");

endmodule

// ----- rtl/key_debounce_event_fifo.sv -----
// ----------------------------------------------------------------------------
// key_debounce_event_fifo
// Three-key debouncer with long-press and auto-repeat codes and an event FIFO.
// ----------------------------------------------------------------------------
// A scan tick (func 0) runs key 0, key 1 and key 2 in turn: each key reads its
// state from the key memory in S_KREAD, then updates it and pushes a code in
// S_KCALC, and passes through S_PUSH2 when it pushes a second code; a tick
// gives no result. A read (func 1) pops one code, or gives 0 when the FIFO is
// empty, through the registered store read, and the block is ready again once
// that result has entered the output register. Scan ticks are taken while an
// earlier result still waits at the output. Pushes are never refused: when the
// write pointer reaches the read pointer the FIFO reads empty.
// No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module key_debounce_event_fifo #(
    parameter int FIFO_DEPTH = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Input channel
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_func,
    input  logic [2:0]                     i_keys_down,
    // Output channel
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [kdb_pkg::CODE_W-1:0]     o_key_code,
    // Configuration write port
    input  logic                           i_cfg_wr_en,
    input  logic [kdb_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [kdb_pkg::TICK_W-1:0]     i_cfg_data
);
    import kdb_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_KREAD = 5'b00010,
        S_KCALC = 5'b00100,
        S_PUSH2 = 5'b01000,
        S_OUT   = 5'b10000
    } t_state;

    t_state            r_state;
    t_state            n_state;
    logic [KEY_W-1:0]  r_key;
    logic [KEY_W-1:0]  n_key;
    logic [2:0]        r_keys;
    logic              r_pop_empty;
    logic [CODE_W-1:0] r_code_b;

    logic [TICK_W-1:0] r_long_ticks [NUM_KEYS];
    logic [TICK_W-1:0] r_rep_ticks  [NUM_KEYS];

    t_key_state        r_kmem [NUM_KEYS];
    logic [NUM_KEYS-1:0] r_kvld;
    t_key_state        r_kq;
    logic              r_kq_vld;
    t_key_state        key_cur;
    t_key_state        key_nxt;
    t_key_ev           key_ev;

    t_fifo_req         fifo_req;
    logic              fifo_empty;
    logic [CODE_W-1:0] fifo_code;

    logic              in_accept;
    logic              out_load;
    logic              r_out_valid;
    logic [CODE_W-1:0] r_key_code;

    assign in_accept = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_KEYS; k++) begin
                r_long_ticks[k] <= LONG_RESET[k];
                r_rep_ticks[k]  <= REPEAT_RESET[k];
            end
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_LONG_KEY0:   r_long_ticks[0] <= i_cfg_data;
                CFG_LONG_KEY1:   r_long_ticks[1] <= i_cfg_data;
                CFG_LONG_KEY2:   r_long_ticks[2] <= i_cfg_data;
                CFG_REPEAT_KEY0: r_rep_ticks[0]  <= i_cfg_data;
                CFG_REPEAT_KEY1: r_rep_ticks[1]  <= i_cfg_data;
                CFG_REPEAT_KEY2: r_rep_ticks[2]  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Sequencer next state: walk the keys for a tick, or pop for a read.
    always_comb begin
        n_state = r_state;
        n_key   = r_key;
        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_key   = '0;
                    n_state = (i_func == FUNC_READ) ? S_OUT : S_KREAD;
                end
            end
            S_KREAD: begin
                n_state = S_KCALC;
            end
            S_KCALC: begin
                if (key_ev.b_vld) begin
                    n_state = S_PUSH2;
                end else if (r_key == KEY_LAST) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_KREAD;
                    n_key   = r_key + KEY_W'(1);
                end
            end
            S_PUSH2: begin
                if (r_key == KEY_LAST) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_KREAD;
                    n_key   = r_key + KEY_W'(1);
                end
            end
            S_OUT: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Sequencer registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_key   <= '0;
        end else begin
            r_state <= n_state;
            r_key   <= n_key;
        end
    end

    // Transaction payload captured on acceptance, and the deferred second code.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_keys      <= i_keys_down;
            r_pop_empty <= fifo_empty;
        end
        if (r_state == S_KCALC) begin
            r_code_b <= key_ev.code_b;
        end
    end

    // Key state memory: registered read, write-back after the update.
    always_ff @(posedge i_clk) begin
        if (r_state == S_KREAD) begin
            r_kq <= r_kmem[r_key];
        end
        if (r_state == S_KCALC) begin
            r_kmem[r_key] <= key_nxt;
        end
    end

    // Entry valid bits: an entry not yet written reads as its reset state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kvld   <= '0;
            r_kq_vld <= 1'b0;
        end else begin
            if (r_state == S_KREAD) begin
                r_kq_vld <= r_kvld[r_key];
            end
            if (r_state == S_KCALC) begin
                r_kvld[r_key] <= 1'b1;
            end
        end
    end

    assign key_cur = r_kq_vld ? r_kq : KEY_STATE_RESET;

    kdb_key_step u_key_step (
        .i_state      (key_cur),
        .i_down       (r_keys[r_key]),
        .i_key        (r_key),
        .i_long_ticks (r_long_ticks[r_key]),
        .i_rep_ticks  (r_rep_ticks[r_key]),
        .o_state      (key_nxt),
        .o_ev         (key_ev)
    );

    // FIFO requests: first code in the update cycle, second code after it.
    always_comb begin
        fifo_req      = '0;
        fifo_req.push = ((r_state == S_KCALC) && key_ev.a_vld) || (r_state == S_PUSH2);
        fifo_req.code = (r_state == S_PUSH2) ? r_code_b : key_ev.code_a;
        fifo_req.pop  = in_accept && (i_func == FUNC_READ) && !fifo_empty;
    end

    kdb_code_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_code_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (fifo_req),
        .o_empty   (fifo_empty),
        .o_rd_code (fifo_code)
    );

    // Output register: loaded when free or being taken in the same cycle.
    assign out_load = (r_state == S_OUT) && (!r_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_key_code <= r_pop_empty ? '0 : fifo_code;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_key_code  = r_key_code;

    // Codes are pushed only while the key walk is in progress.
    a_push_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fifo_req.push |-> ((r_state == S_KCALC) || (r_state == S_PUSH2)))
        else $error("FIFO push outside key walk");

    // The key index never reaches past the last key.
    a_key_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_key <= KEY_LAST))
        else $error("key index out of range");

    // A new result follows only from the read path.
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> $past(in_accept && (i_func == FUNC_READ)) || (r_state == S_OUT))
        else $error("result loaded without a read transaction");

endmodule
